@@ rtl/cel_shade_vertex_intensity_top_defines.svh @@
// assertion macros used by the checker file
`ifndef CEL_SHADE_VERTEX_INTENSITY_TOP_DEFINES_SVH
`define CEL_SHADE_VERTEX_INTENSITY_TOP_DEFINES_SVH

// expression must hold at every clock edge out of reset
`define CVI_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("cvi check failed");

// antecedent implies consequent in the same cycle
`define CVI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cvi check failed");

`endif

@@ rtl/cvi_pkg.sv @@
// shared constants and types of the vertex intensity block
package cvi_pkg;

    localparam int FRAC_BITS   = 14;
    localparam int TOON_LEVELS = 32;

    localparam int COEF_W   = 16;
    localparam int CFG_W    = 3 * COEF_W;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W   = 2 * COEF_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int RAW_W    = PROD_W;
    localparam int MAG_W    = 30;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUMSQ_W  = SQ_W + 2;
    localparam int LP_W     = MAG_W + 1 + COEF_W;
    localparam int DOT_W    = LP_W + 1;
    localparam int NUM_W    = DOT_W;
    localparam int RES_W    = SUMSQ_W + 1;
    localparam int ROOT_W   = SUMSQ_W / 2;
    localparam int STEP_W   = 5;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int QUO_W    = 17;
    localparam int SHADE_W  = 16;
    localparam int TOON_W   = $clog2(TOON_LEVELS);
    localparam int TOON_SHIFT = 15 - TOON_W;
    localparam int NUM_SHIFT  = 15 - FRAC_BITS;

    localparam logic [SHADE_W-1:0] ONE_Q15 = SHADE_W'(32768);

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT = CFG_IDX_W'(3);

    localparam logic [CFG_W-1:0] ROW_X_RST = CFG_W'(1) << FRAC_BITS;
    localparam logic [CFG_W-1:0] ROW_Y_RST = CFG_W'(1) << (FRAC_BITS + 16);
    localparam logic [CFG_W-1:0] ROW_Z_RST = CFG_W'(1) << (FRAC_BITS + 32);
    localparam logic [CFG_W-1:0] LIGHT_RST = CFG_W'(1) << (FRAC_BITS + 32);

    typedef struct packed {
        logic vld;
        logic last;
        logic zero;
        logic pos;
        logic sat;
    } t_ctl;

endpackage

@@ rtl/cvi_front.sv @@
// rotation, magnitude scaling, squares and light dot product stages
module cvi_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_acc,
    input  logic signed [cvi_pkg::COEF_W-1:0]   i_nx,
    input  logic signed [cvi_pkg::COEF_W-1:0]   i_ny,
    input  logic signed [cvi_pkg::COEF_W-1:0]   i_nz,
    input  logic                                i_last,
    input  logic [cvi_pkg::CFG_W-1:0]           i_row_x,
    input  logic [cvi_pkg::CFG_W-1:0]           i_row_y,
    input  logic [cvi_pkg::CFG_W-1:0]           i_row_z,
    input  logic [cvi_pkg::CFG_W-1:0]           i_light,
    output cvi_pkg::t_ctl                       o_ctl,
    output logic [cvi_pkg::SUMSQ_W-1:0]         o_sumsq,
    output logic [cvi_pkg::NUM_W-1:0]           o_num
);
    localparam int CW = cvi_pkg::COEF_W;

    cvi_pkg::t_ctl r_c1, r_c2, r_c3, r_c4, r_c5;
    logic signed [cvi_pkg::PROD_W-1:0] r_prod [3][3];
    logic signed [cvi_pkg::SUM_W-1:0]  r_sum [3];
    logic [cvi_pkg::MAG_W-1:0]         r_mag [3];
    logic [2:0]                        r_neg;
    logic [cvi_pkg::SQ_W-1:0]          r_sq [3];
    logic signed [cvi_pkg::LP_W-1:0]   r_lp [3];
    logic [cvi_pkg::SUMSQ_W-1:0]       r_sumsq;
    logic [cvi_pkg::NUM_W-1:0]         r_num;

    logic [cvi_pkg::CFG_W-1:0]         w_rows [3];
    logic signed [CW-1:0]              w_n [3];
    logic [cvi_pkg::RAW_W-1:0]         w_raw [3];
    logic                              w_big;
    logic signed [cvi_pkg::LP_W-1:0]   w_lp [3];
    logic signed [cvi_pkg::DOT_W-1:0]  w_dot;
    logic [cvi_pkg::SUMSQ_W-1:0]       w_sumsq;

    assign w_rows[0] = i_row_x;
    assign w_rows[1] = i_row_y;
    assign w_rows[2] = i_row_z;
    assign w_n[0] = i_nx;
    assign w_n[1] = i_ny;
    assign w_n[2] = i_nz;

    // magnitudes and common scale when any term is large
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_raw[i] = r_sum[i][cvi_pkg::SUM_W-1] ? cvi_pkg::RAW_W'(-r_sum[i])
                                                  : cvi_pkg::RAW_W'(r_sum[i]);
        end
        w_big = (w_raw[0][cvi_pkg::RAW_W-1:cvi_pkg::MAG_W] != '0) ||
                (w_raw[1][cvi_pkg::RAW_W-1:cvi_pkg::MAG_W] != '0) ||
                (w_raw[2][cvi_pkg::RAW_W-1:cvi_pkg::MAG_W] != '0);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_lp[i] = $signed({1'b0, r_mag[i]}) * $signed(i_light[CW*i +: CW]);
        end
        w_sumsq = cvi_pkg::SUMSQ_W'(r_sq[0]) + cvi_pkg::SUMSQ_W'(r_sq[1])
                + cvi_pkg::SUMSQ_W'(r_sq[2]);
        w_dot = cvi_pkg::DOT_W'(r_lp[0]) + cvi_pkg::DOT_W'(r_lp[1])
              + cvi_pkg::DOT_W'(r_lp[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
        end else begin
            r_c1 <= '{vld: i_acc, last: i_last, zero: 1'b0, pos: 1'b0, sat: 1'b0};
            r_c2 <= r_c1;
            r_c3 <= r_c2;
            r_c4 <= r_c3;
            r_c5 <= '{vld: r_c4.vld, last: r_c4.last, zero: (w_sumsq == '0),
                      pos: (w_dot > 0), sat: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[i][k] <= $signed(w_rows[i][CW*k +: CW]) * w_n[k];
            end
            r_sum[i] <= cvi_pkg::SUM_W'(r_prod[i][0]) + cvi_pkg::SUM_W'(r_prod[i][1])
                      + cvi_pkg::SUM_W'(r_prod[i][2]);
            r_mag[i] <= w_big ? cvi_pkg::MAG_W'(w_raw[i] >> 2) : cvi_pkg::MAG_W'(w_raw[i]);
            r_neg[i] <= r_sum[i][cvi_pkg::SUM_W-1];
            r_sq[i]  <= cvi_pkg::SQ_W'(r_mag[i]) * cvi_pkg::SQ_W'(r_mag[i]);
            r_lp[i]  <= r_neg[i] ? -w_lp[i] : w_lp[i];
        end
        r_sumsq <= w_sumsq;
        r_num   <= (w_dot > 0) ? cvi_pkg::NUM_W'(w_dot <<< cvi_pkg::NUM_SHIFT) : '0;
    end

    assign o_ctl   = r_c5;
    assign o_sumsq = r_sumsq;
    assign o_num   = r_num;

endmodule

@@ rtl/cvi_sqrt_cell.sv @@
// one bit-pair step of the integer square root chain
module cvi_sqrt_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [cvi_pkg::STEP_W-1:0]      i_step,
    input  cvi_pkg::t_ctl                   i_ctl,
    input  logic [cvi_pkg::SUMSQ_W-1:0]     i_rem,
    input  logic [cvi_pkg::RES_W-1:0]       i_root,
    input  logic [cvi_pkg::NUM_W-1:0]       i_num,
    output cvi_pkg::t_ctl                   o_ctl,
    output logic [cvi_pkg::SUMSQ_W-1:0]     o_rem,
    output logic [cvi_pkg::RES_W-1:0]       o_root,
    output logic [cvi_pkg::NUM_W-1:0]       o_num
);
    cvi_pkg::t_ctl                  r_ctl;
    logic [cvi_pkg::SUMSQ_W-1:0]    r_rem;
    logic [cvi_pkg::RES_W-1:0]      r_root;
    logic [cvi_pkg::NUM_W-1:0]      r_num;

    logic [cvi_pkg::RES_W-1:0]      w_bit;
    logic [cvi_pkg::RES_W-1:0]      w_trial;
    logic                           w_ge;

    always_comb begin
        w_bit   = cvi_pkg::RES_W'(1) << {i_step, 1'b0};
        w_trial = i_root + w_bit;
        w_ge    = {1'b0, i_rem} >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= w_ge ? i_rem - cvi_pkg::SUMSQ_W'(w_trial) : i_rem;
        r_root <= w_ge ? (i_root >> 1) + w_bit : i_root >> 1;
        r_num  <= i_num;
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_num  = r_num;

endmodule

@@ rtl/cvi_div_cell.sv @@
// one quotient bit of the restoring divider chain
module cvi_div_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [cvi_pkg::STEP_W-1:0]      i_step,
    input  cvi_pkg::t_ctl                   i_ctl,
    input  logic [cvi_pkg::NUM_W-1:0]       i_rem,
    input  logic [cvi_pkg::ROOT_W-1:0]      i_den,
    input  logic [cvi_pkg::QUO_W-1:0]       i_quo,
    output cvi_pkg::t_ctl                   o_ctl,
    output logic [cvi_pkg::NUM_W-1:0]       o_rem,
    output logic [cvi_pkg::ROOT_W-1:0]      o_den,
    output logic [cvi_pkg::QUO_W-1:0]       o_quo
);
    cvi_pkg::t_ctl                  r_ctl;
    logic [cvi_pkg::NUM_W-1:0]      r_rem;
    logic [cvi_pkg::ROOT_W-1:0]     r_den;
    logic [cvi_pkg::QUO_W-1:0]      r_quo;

    logic [cvi_pkg::NUM_W-1:0]      w_sub;
    logic                           w_ge;

    always_comb begin
        w_sub = cvi_pkg::NUM_W'(i_den) << i_step;
        w_ge  = i_rem >= w_sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= w_ge ? i_rem - w_sub : i_rem;
        r_den <= i_den;
        r_quo <= w_ge ? i_quo | (cvi_pkg::QUO_W'(1) << i_step) : i_quo;
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;

endmodule

@@ rtl/cel_shade_vertex_intensity_top.sv @@
// top level of the per-vertex cel-shading intensity pipeline
//
// usage
//   input: pulse start with a vertex normal (x, y, z in signed q2.14) and the
//   last-vertex mark; busy is held low, so an item is taken on every cycle
//   that start is high
//   output: o_strobe is high for one cycle with o_shade (unsigned q1.15),
//   o_toon_index, o_zero_normal and o_last_out; results leave in input order
//   stages from the accepting edge to the edge that takes the result:
//   5 front stages, 31 square root cells, 1 saturation check,
//   17 divider cells, 1 output register
//   throughput: one item per cycle, set by the cell chain which moves every
//   item one cell forward each clock
//   configuration: write i_cfg_we / i_cfg_idx / i_cfg_data while no item is
//   in flight; index 0..2 are the matrix rows, 3 the light vector, others
//   are dropped
//   reset: synchronous active low, clears every stage valid bit and loads
//   the identity matrix and a light along +z
//   the receiver cannot stall; a result is shown exactly once
module cel_shade_vertex_intensity_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [cvi_pkg::COEF_W-1:0]   i_normal_x,
    input  logic signed [cvi_pkg::COEF_W-1:0]   i_normal_y,
    input  logic signed [cvi_pkg::COEF_W-1:0]   i_normal_z,
    input  logic                                i_last_vertex,
    input  logic                                i_cfg_we,
    input  logic [cvi_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [cvi_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                                o_strobe,
    output logic [cvi_pkg::SHADE_W-1:0]         o_shade,
    output logic [cvi_pkg::TOON_W-1:0]          o_toon_index,
    output logic                                o_zero_normal,
    output logic                                o_last_out
);
    localparam int NS = cvi_pkg::SQRT_STEPS;
    localparam int NQ = cvi_pkg::QUO_W;

    // configuration registers
    logic [cvi_pkg::CFG_W-1:0] r_row_x, r_row_y, r_row_z, r_light;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x <= cvi_pkg::ROW_X_RST;
            r_row_y <= cvi_pkg::ROW_Y_RST;
            r_row_z <= cvi_pkg::ROW_Z_RST;
            r_light <= cvi_pkg::LIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cvi_pkg::CFG_ROW_X: r_row_x <= i_cfg_data;
                cvi_pkg::CFG_ROW_Y: r_row_y <= i_cfg_data;
                cvi_pkg::CFG_ROW_Z: r_row_z <= i_cfg_data;
                cvi_pkg::CFG_LIGHT: r_light <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // never stalls: the chain advances every cycle
    assign busy = 1'b0;

    // front stages: rotate, scale, square, dot with light
    cvi_pkg::t_ctl                  w_sq_ctl  [NS+1];
    logic [cvi_pkg::SUMSQ_W-1:0]    w_sq_rem  [NS+1];
    logic [cvi_pkg::RES_W-1:0]      w_sq_root [NS+1];
    logic [cvi_pkg::NUM_W-1:0]      w_sq_num  [NS+1];

    cvi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (start && !busy),
        .i_nx    (i_normal_x),
        .i_ny    (i_normal_y),
        .i_nz    (i_normal_z),
        .i_last  (i_last_vertex),
        .i_row_x (r_row_x),
        .i_row_y (r_row_y),
        .i_row_z (r_row_z),
        .i_light (r_light),
        .o_ctl   (w_sq_ctl[0]),
        .o_sumsq (w_sq_rem[0]),
        .o_num   (w_sq_num[0])
    );
    assign w_sq_root[0] = '0;

    // square root chain, highest bit pair first
    for (genvar g = 0; g < NS; g++) begin : g_sqrt
        cvi_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (cvi_pkg::STEP_W'(NS - 1 - g)),
            .i_ctl   (w_sq_ctl[g]),
            .i_rem   (w_sq_rem[g]),
            .i_root  (w_sq_root[g]),
            .i_num   (w_sq_num[g]),
            .o_ctl   (w_sq_ctl[g+1]),
            .o_rem   (w_sq_rem[g+1]),
            .o_root  (w_sq_root[g+1]),
            .o_num   (w_sq_num[g+1])
        );
    end

    // saturation check: quotient would reach 2^17 or more
    cvi_pkg::t_ctl                  r_sc_ctl;
    logic [cvi_pkg::NUM_W-1:0]      r_sc_num;
    logic [cvi_pkg::ROOT_W-1:0]     r_sc_den;
    logic [cvi_pkg::ROOT_W-1:0]     w_len;
    logic                           w_sat;

    always_comb begin
        w_len = cvi_pkg::ROOT_W'(w_sq_root[NS]);
        w_sat = cvi_pkg::ROOT_W'(w_sq_num[NS] >> NQ) >= w_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_ctl <= '0;
        end else begin
            r_sc_ctl <= '{vld: w_sq_ctl[NS].vld, last: w_sq_ctl[NS].last,
                          zero: w_sq_ctl[NS].zero, pos: w_sq_ctl[NS].pos, sat: w_sat};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sc_num <= w_sq_num[NS];
        r_sc_den <= w_len;
    end

    // restoring divider chain, one quotient bit per cell
    cvi_pkg::t_ctl                  w_dv_ctl [NQ+1];
    logic [cvi_pkg::NUM_W-1:0]      w_dv_rem [NQ+1];
    logic [cvi_pkg::ROOT_W-1:0]     w_dv_den [NQ+1];
    logic [cvi_pkg::QUO_W-1:0]      w_dv_quo [NQ+1];

    assign w_dv_ctl[0] = r_sc_ctl;
    assign w_dv_rem[0] = r_sc_num;
    assign w_dv_den[0] = r_sc_den;
    assign w_dv_quo[0] = '0;

    for (genvar g = 0; g < NQ; g++) begin : g_div
        cvi_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (cvi_pkg::STEP_W'(NQ - 1 - g)),
            .i_ctl   (w_dv_ctl[g]),
            .i_rem   (w_dv_rem[g]),
            .i_den   (w_dv_den[g]),
            .i_quo   (w_dv_quo[g]),
            .o_ctl   (w_dv_ctl[g+1]),
            .o_rem   (w_dv_rem[g+1]),
            .o_den   (w_dv_den[g+1]),
            .o_quo   (w_dv_quo[g+1])
        );
    end

    // output register: clamp, toon level, flags
    cvi_pkg::t_ctl                  w_oc;
    logic [cvi_pkg::SHADE_W-1:0]    n_shade;
    logic [cvi_pkg::TOON_W-1:0]     n_toon;
    logic                           r_strobe;
    logic [cvi_pkg::SHADE_W-1:0]    r_shade;
    logic [cvi_pkg::TOON_W-1:0]     r_toon;
    logic                           r_zero;
    logic                           r_last;

    always_comb begin
        w_oc = w_dv_ctl[NQ];
        if (w_oc.zero || !w_oc.pos) begin
            n_shade = '0;
        end else if (w_oc.sat || (w_dv_quo[NQ] > cvi_pkg::QUO_W'(cvi_pkg::ONE_Q15))) begin
            n_shade = cvi_pkg::ONE_Q15;
        end else begin
            n_shade = cvi_pkg::SHADE_W'(w_dv_quo[NQ]);
        end
        // full scale maps one past the top level, so clamp it
        if (n_shade[cvi_pkg::SHADE_W-1]) begin
            n_toon = '1;
        end else begin
            n_toon = cvi_pkg::TOON_W'(n_shade >> cvi_pkg::TOON_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_oc.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shade <= n_shade;
        r_toon  <= n_toon;
        r_zero  <= w_oc.zero;
        r_last  <= w_oc.last;
    end

    assign o_strobe      = r_strobe;
    assign o_shade       = r_shade;
    assign o_toon_index  = r_toon;
    assign o_zero_normal = r_zero;
    assign o_last_out    = r_last;

endmodule

@@ rtl/cvi_checker.sv @@
// port level checks of the vertex intensity block and their binding
`include "cel_shade_vertex_intensity_top_defines.svh"

module cvi_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                busy,
    input  logic                                o_strobe,
    input  logic [cvi_pkg::SHADE_W-1:0]         o_shade,
    input  logic [cvi_pkg::TOON_W-1:0]          o_toon_index,
    input  logic                                o_zero_normal
);
    logic w_toon_ok;

    assign w_toon_ok = (o_shade == cvi_pkg::ONE_Q15) ? (o_toon_index == '1)
        : (o_toon_index == cvi_pkg::TOON_W'(o_shade >> cvi_pkg::TOON_SHIFT));

    `CVI_ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !busy)
    `CVI_ASSERT_IMPL(a_shade_range, i_clk, i_rst_n, o_strobe, o_shade <= cvi_pkg::ONE_Q15)
    `CVI_ASSERT_IMPL(a_toon_match, i_clk, i_rst_n, o_strobe, w_toon_ok)
    `CVI_ASSERT_IMPL(a_zero_dark, i_clk, i_rst_n, o_strobe && o_zero_normal, o_shade == '0)
    `CVI_ASSERT_IMPL(a_reset_quiet, i_clk, i_rst_n, $past(!i_rst_n), !o_strobe)

endmodule

bind cel_shade_vertex_intensity_top cvi_checker u_cvi_checker (.*);
